// ----- rtl/wrlm_pkg.sv -----
package wrlm_pkg;

    localparam int WINDOW_DEPTH = 64;
    localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
    localparam int LEN_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int DATA_W       = 48;
    localparam int ACC_W        = DATA_W + ADDR_W;
    localparam int LIMIT_W      = 32;
    localparam int WIN_W        = 7;
    localparam int CPU_LIMIT_W  = 7;
    localparam int MUL_A_W      = LIMIT_W + 1 + LEN_W;
    localparam int MUL_B_W      = (LEN_W > CPU_LIMIT_W + 1) ? LEN_W : CPU_LIMIT_W + 1;
    localparam int PROD_W       = MUL_A_W + MUL_B_W;
    localparam int CMP_W        = (ACC_W > PROD_W) ? ACC_W : PROD_W;
    localparam int CFG_IDX_W    = 3;

    localparam logic [LIMIT_W-1:0] POLL_RESET = LIMIT_W'(30 * 1000);

    localparam logic [CFG_IDX_W-1:0] REG_MEM_LIMIT   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MEM_WINDOW  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CPU_LIMIT   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_CPU_WINDOW  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_POLL        = CFG_IDX_W'(4);

    typedef enum logic [2:0] {
        ALU_NOP,
        ALU_CLR,
        ALU_ADD,
        ALU_LOAD,
        ALU_SUB,
        ALU_MUL,
        ALU_MULP
    } alu_op_t;

    typedef struct packed {
        logic              clear;
        logic              push;
        logic [ADDR_W-1:0] rd_addr;
    } ring_ctrl_t;

    function automatic logic [LEN_W-1:0] ring_len(input logic [WIN_W-1:0] win);
        logic [LEN_W-1:0] len;
        if (win < WIN_W'(2))
        begin
            len = LEN_W'(2);
        end
        else if (int'(win) > WINDOW_DEPTH)
        begin
            len = LEN_W'(WINDOW_DEPTH);
        end
        else
        begin
            len = LEN_W'(win);
        end
        return len;
    endfunction

endpackage

// ----- rtl/wrlm_ring.sv -----
module wrlm_ring (
    input  logic                         clk,
    input  logic                         rst_n,
    input  wrlm_pkg::ring_ctrl_t         ctrl,
    input  logic [wrlm_pkg::LEN_W-1:0]   len,
    input  logic [wrlm_pkg::DATA_W-1:0]  wr_data,
    output logic [wrlm_pkg::DATA_W-1:0]  rd_data,
    output logic [wrlm_pkg::ADDR_W-1:0]  slot,
    output logic                         filled
);
    import wrlm_pkg::*;

    logic [DATA_W-1:0]       ram [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] valid_reg;
    logic [ADDR_W-1:0]       slot_reg;
    logic                    filled_reg;
    logic [DATA_W-1:0]       rd_data_reg;
    logic                    rd_valid_reg;

    logic [ADDR_W-1:0]       wr_slot;
    logic [LEN_W-1:0]        inc;
    logic                    wrap;
    logic [ADDR_W-1:0]       slot_adv;

    always_comb
    begin
        wr_slot  = (LEN_W'(slot_reg) >= len) ? '0 : slot_reg;
        inc      = LEN_W'(wr_slot) + LEN_W'(1);
        wrap     = (inc >= len);
        slot_adv = wrap ? '0 : inc[ADDR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            slot_reg     <= '0;
            filled_reg   <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[ctrl.rd_addr];
            if (ctrl.clear)
            begin
                valid_reg  <= '0;
                slot_reg   <= '0;
                filled_reg <= 1'b0;
            end
            else if (ctrl.push)
            begin
                valid_reg[wr_slot] <= 1'b1;
                slot_reg           <= slot_adv;
                filled_reg         <= filled_reg | wrap;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            ram[wr_slot] <= wr_data;
        end
        rd_data_reg <= ram[ctrl.rd_addr];
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;
    assign slot    = slot_reg;
    assign filled  = filled_reg;

endmodule

// ----- rtl/wrlm_alu.sv -----
module wrlm_alu (
    input  logic                          clk,
    input  wrlm_pkg::alu_op_t             op,
    input  logic [wrlm_pkg::DATA_W-1:0]   opa,
    input  logic [wrlm_pkg::MUL_B_W-1:0]  mulb,
    output logic                          ge
);
    import wrlm_pkg::*;

    logic [ACC_W-1:0]  acc_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [DATA_W-1:0] diff;

    assign diff = opa - acc_reg[DATA_W-1:0];

    always_ff @(posedge clk)
    begin
        unique case (op)
            ALU_CLR:  acc_reg <= '0;
            ALU_ADD:  acc_reg <= acc_reg + ACC_W'(opa);
            ALU_LOAD: acc_reg <= ACC_W'(opa);
            ALU_SUB:  acc_reg <= ACC_W'(diff);
            ALU_MUL:  prod_reg <= {{MUL_B_W{1'b0}}, opa[MUL_A_W-1:0]}
                                  * {{MUL_A_W{1'b0}}, mulb};
            ALU_MULP: prod_reg <= {{MUL_B_W{1'b0}}, prod_reg[MUL_A_W-1:0]}
                                  * {{MUL_A_W{1'b0}}, mulb};
            default:  ;
        endcase
    end

    assign ge = (CMP_W'(acc_reg) >= CMP_W'(prod_reg));

endmodule

// ----- rtl/windowed_resource_limit_monitor.sv -----
// Windowed resource-limit monitor.
// Each word on the s_axis channel is one poll tick carrying a memory sample
// and a cumulative CPU-time sample. Each enabled check stores its sample in a
// ring; once the ring has wrapped, the memory check compares the ring mean with
// mem_limit and the CPU check compares the CPU-time rise across the ring,
// divided by the window time, with cpu_limit. One word with both flags leaves
// on the m_axis channel for every word taken in.
// Registers are written through the cfg channel, which is always ready; a
// window write clears that ring. Writes are expected while the block is idle.
// A tick runs the memory check and then the CPU check before the result register
// is loaded: the mean is summed one ring entry at a time, each read through the
// single ring read port and added in the shared adder, and the limit comparisons
// use one shared multiplier over three steps. A check that is disabled or whose
// ring has not yet wrapped is skipped.
// s_axis_tready is high only while no tick is being worked on. A finished
// result waits in the output register while m_axis_tready is low; the next
// tick is taken meanwhile but its result is held until the register frees.
// Reset clears both rings, their fill state and the output, and sets the
// registers to their defaults.
module windowed_resource_limit_monitor (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // rss_sample [47:0], cpu_sample [95:48]
    input  logic [2*wrlm_pkg::DATA_W-1:0]      s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // mem_over [0], cpu_over [1], zero [7:2]
    output logic [7:0]                         m_axis_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [wrlm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wrlm_pkg::LIMIT_W-1:0]       cfg_data
);
    import wrlm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH,
        S_MEM_CHK,
        S_MEM_RD,
        S_MEM_ACC,
        S_MEM_MUL,
        S_MEM_CMP,
        S_CPU_CHK,
        S_CPU_RDO,
        S_CPU_RDN,
        S_CPU_SUB,
        S_CPU_MUL1,
        S_CPU_MUL2,
        S_CPU_CMP,
        S_DONE
    } state_t;

    logic [LIMIT_W-1:0]     mem_limit_reg;
    logic [WIN_W-1:0]       mem_win_reg;
    logic [CPU_LIMIT_W-1:0] cpu_limit_reg;
    logic [WIN_W-1:0]       cpu_win_reg;
    logic [LIMIT_W-1:0]     poll_reg;

    state_t                 state_reg, state_next;
    logic [LEN_W-1:0]       idx_reg, idx_next;
    logic [DATA_W-1:0]      rss_reg, rss_next;
    logic [DATA_W-1:0]      cpu_reg, cpu_next;
    logic                   mem_over_reg, mem_over_next;
    logic                   cpu_over_reg, cpu_over_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_mem_reg, out_mem_next;
    logic                   out_cpu_reg, out_cpu_next;

    logic                   cfg_write;
    logic [LEN_W-1:0]       mem_len;
    logic [LEN_W-1:0]       cpu_len;
    logic [LIMIT_W-1:0]     poll_ms;
    logic                   mem_en;
    logic                   cpu_en;
    logic [ADDR_W-1:0]      newest;

    ring_ctrl_t             mem_ctrl;
    ring_ctrl_t             cpu_ctrl;
    logic [DATA_W-1:0]      mem_rd_data;
    logic [DATA_W-1:0]      cpu_rd_data;
    logic [ADDR_W-1:0]      mem_slot;
    logic [ADDR_W-1:0]      cpu_slot;
    logic                   mem_filled;
    logic                   cpu_filled;

    alu_op_t                alu_op;
    logic [DATA_W-1:0]      alu_opa;
    logic [MUL_B_W-1:0]     alu_mulb;
    logic                   alu_ge;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_limit_reg <= '0;
            mem_win_reg   <= WIN_W'(2);
            cpu_limit_reg <= '0;
            cpu_win_reg   <= WIN_W'(2);
            poll_reg      <= POLL_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MEM_LIMIT:  mem_limit_reg <= cfg_data;
                REG_MEM_WINDOW: mem_win_reg   <= cfg_data[WIN_W-1:0];
                REG_CPU_LIMIT:  cpu_limit_reg <= cfg_data[CPU_LIMIT_W-1:0];
                REG_CPU_WINDOW: cpu_win_reg   <= cfg_data[WIN_W-1:0];
                REG_POLL:       poll_reg      <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign mem_len = ring_len(mem_win_reg);
    assign cpu_len = ring_len(cpu_win_reg);
    assign poll_ms = (poll_reg == '0) ? LIMIT_W'(1) : poll_reg;
    assign mem_en  = (mem_limit_reg != '0);
    assign cpu_en  = (cpu_limit_reg != '0);
    assign newest  = (cpu_slot == '0) ? ADDR_W'(cpu_len - LEN_W'(1))
                                      : cpu_slot - ADDR_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        rss_next       = rss_reg;
        cpu_next       = cpu_reg;
        mem_over_next  = mem_over_reg;
        cpu_over_next  = cpu_over_reg;
        out_valid_next = out_valid_reg;
        out_mem_next   = out_mem_reg;
        out_cpu_next   = out_cpu_reg;

        alu_op   = ALU_NOP;
        alu_opa  = '0;
        alu_mulb = '0;

        mem_ctrl.clear   = cfg_write && (cfg_index == REG_MEM_WINDOW);
        mem_ctrl.push    = 1'b0;
        mem_ctrl.rd_addr = idx_reg[ADDR_W-1:0];
        cpu_ctrl.clear   = cfg_write && (cfg_index == REG_CPU_WINDOW);
        cpu_ctrl.push    = 1'b0;
        cpu_ctrl.rd_addr = cpu_slot;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    rss_next      = s_axis_tdata[DATA_W-1:0];
                    cpu_next      = s_axis_tdata[2*DATA_W-1:DATA_W];
                    mem_over_next = 1'b0;
                    cpu_over_next = 1'b0;
                    idx_next      = '0;
                    alu_op        = ALU_CLR;
                    state_next    = S_PUSH;
                end
            end
            S_PUSH:
            begin
                mem_ctrl.push = mem_en;
                cpu_ctrl.push = cpu_en;
                state_next    = S_MEM_CHK;
            end
            S_MEM_CHK:
            begin
                state_next = (mem_en && mem_filled) ? S_MEM_RD : S_CPU_CHK;
            end
            S_MEM_RD:
            begin
                state_next = S_MEM_ACC;
            end
            S_MEM_ACC:
            begin
                alu_op   = ALU_ADD;
                alu_opa  = mem_rd_data;
                idx_next = idx_reg + LEN_W'(1);
                state_next = (idx_next == mem_len) ? S_MEM_MUL : S_MEM_RD;
            end
            S_MEM_MUL:
            begin
                alu_op     = ALU_MUL;
                alu_opa    = DATA_W'({1'b0, mem_limit_reg} + (LIMIT_W + 1)'(1));
                alu_mulb   = MUL_B_W'(mem_len);
                state_next = S_MEM_CMP;
            end
            S_MEM_CMP:
            begin
                mem_over_next = alu_ge;
                state_next    = S_CPU_CHK;
            end
            S_CPU_CHK:
            begin
                state_next = (cpu_en && cpu_filled) ? S_CPU_RDO : S_DONE;
            end
            S_CPU_RDO:
            begin
                state_next = S_CPU_RDN;
            end
            S_CPU_RDN:
            begin
                alu_op           = ALU_LOAD;
                alu_opa          = cpu_rd_data;
                cpu_ctrl.rd_addr = newest;
                state_next       = S_CPU_SUB;
            end
            S_CPU_SUB:
            begin
                alu_op     = ALU_SUB;
                alu_opa    = cpu_rd_data;
                state_next = S_CPU_MUL1;
            end
            S_CPU_MUL1:
            begin
                alu_op     = ALU_MUL;
                alu_opa    = DATA_W'(poll_ms);
                alu_mulb   = MUL_B_W'(cpu_len - LEN_W'(1));
                state_next = S_CPU_MUL2;
            end
            S_CPU_MUL2:
            begin
                alu_op     = ALU_MULP;
                alu_mulb   = MUL_B_W'({1'b0, cpu_limit_reg} + (CPU_LIMIT_W + 1)'(1));
                state_next = S_CPU_CMP;
            end
            S_CPU_CMP:
            begin
                cpu_over_next = alu_ge;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_mem_next   = mem_over_reg;
                    out_cpu_next   = cpu_over_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            mem_over_reg  <= 1'b0;
            cpu_over_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_mem_reg   <= 1'b0;
            out_cpu_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            mem_over_reg  <= mem_over_next;
            cpu_over_reg  <= cpu_over_next;
            out_valid_reg <= out_valid_next;
            out_mem_reg   <= out_mem_next;
            out_cpu_reg   <= out_cpu_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rss_reg <= rss_next;
        cpu_reg <= cpu_next;
    end

    wrlm_ring u_mem_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mem_ctrl),
        .len     (mem_len),
        .wr_data (rss_reg),
        .rd_data (mem_rd_data),
        .slot    (mem_slot),
        .filled  (mem_filled)
    );

    wrlm_ring u_cpu_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (cpu_ctrl),
        .len     (cpu_len),
        .wr_data (cpu_reg),
        .rd_data (cpu_rd_data),
        .slot    (cpu_slot),
        .filled  (cpu_filled)
    );

    wrlm_alu u_alu (
        .clk  (clk),
        .op   (alu_op),
        .opa  (alu_opa),
        .mulb (alu_mulb),
        .ge   (alu_ge)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_cpu_reg, out_mem_reg};

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import wrlm_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_TICKS   = 1400;
    localparam int NUM_ROWS       = 27;
    localparam int MEM_RING       = 0;
    localparam int CPU_RING       = 1;

    localparam logic [DATA_W-1:0]    SAMPLE_MAX    = '1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = REG_POLL + CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = '1;

    typedef struct packed {
        logic cpu_over;
        logic mem_over;
    } flags_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_TICK,
        ROW_TICK_KNOWN
    } row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] index;
        logic [LIMIT_W-1:0]   value;
        logic [DATA_W-1:0]    rss;
        logic [DATA_W-1:0]    cpu;
        logic                 mem_over;
        logic                 cpu_over;
    } row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [2*DATA_W-1:0]    s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [7:0]             m_axis_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [LIMIT_W-1:0]     cfg_data;

    logic [LIMIT_W-1:0]     mem_limit_q;
    logic [WIN_W-1:0]       mem_win_q;
    logic [CPU_LIMIT_W-1:0] cpu_limit_q;
    logic [WIN_W-1:0]       cpu_win_q;
    logic [LIMIT_W-1:0]     poll_q;
    logic [DATA_W-1:0]      ring_hist [2][WINDOW_DEPTH];
    int                     ring_pos [2];
    bit                     ring_full [2];

    flags_t                 pending_flags [$];
    row_t                   plan [NUM_ROWS];
    int                     errors = 0;
    int                     ticks_sent = 0;
    int                     results_seen = 0;
    int                     mem_flags_seen = 0;
    int                     cpu_flags_seen = 0;
    int                     regs_written = 0;
    int                     idle_cycles = 0;

    windowed_resource_limit_monitor i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int eff_len(input logic [WIN_W-1:0] w);
        if (w < WIN_W'(2))
        begin
            return 2;
        end
        if (int'(w) > WINDOW_DEPTH)
        begin
            return WINDOW_DEPTH;
        end
        return int'(w);
    endfunction

    function automatic void clear_ring(input int r);
        int i;
        for (i = 0; i < WINDOW_DEPTH; i++)
        begin
            ring_hist[r][i] = '0;
        end
        ring_pos[r]  = 0;
        ring_full[r] = 1'b0;
    endfunction

    function automatic bit push_sample(input int r, input int len, input logic [DATA_W-1:0] s);
        int p;
        p = ring_pos[r];
        if (p >= len)
        begin
            p = 0;
        end
        ring_hist[r][p] = s;
        p++;
        if (p >= len)
        begin
            p = 0;
        end
        ring_pos[r]  = p;
        ring_full[r] = ring_full[r] || (p == 0);
        return ring_full[r];
    endfunction

    function automatic flags_t predict_flags(input logic [DATA_W-1:0] rss,
                                             input logic [DATA_W-1:0] cpu);
        flags_t            f;
        int                len;
        int                i;
        int                newest;
        logic [63:0]       total;
        logic [63:0]       span;
        logic [DATA_W-1:0] rise;
        f = '0;
        if (mem_limit_q != '0)
        begin
            len = eff_len(mem_win_q);
            if (push_sample(MEM_RING, len, rss))
            begin
                total = '0;
                for (i = 0; i < len; i++)
                begin
                    total += 64'(ring_hist[MEM_RING][i]);
                end
                f.mem_over = (total / 64'(len)) > 64'(mem_limit_q);
            end
        end
        if (cpu_limit_q != '0)
        begin
            len = eff_len(cpu_win_q);
            if (push_sample(CPU_RING, len, cpu))
            begin
                newest = (ring_pos[CPU_RING] == 0) ? len - 1 : ring_pos[CPU_RING] - 1;
                rise = ring_hist[CPU_RING][newest] - ring_hist[CPU_RING][ring_pos[CPU_RING]];
                span = 64'(len - 1) * ((poll_q == '0) ? 64'd1 : 64'(poll_q));
                f.cpu_over = (64'(rise) / span) > 64'(cpu_limit_q);
            end
        end
        return f;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [LIMIT_W-1:0] v);
        case (idx)
            REG_MEM_LIMIT:
            begin
                mem_limit_q = v;
            end
            REG_MEM_WINDOW:
            begin
                mem_win_q = v[WIN_W-1:0];
                clear_ring(MEM_RING);
            end
            REG_CPU_LIMIT:
            begin
                cpu_limit_q = v[CPU_LIMIT_W-1:0];
            end
            REG_CPU_WINDOW:
            begin
                cpu_win_q = v[WIN_W-1:0];
                clear_ring(CPU_RING);
            end
            REG_POLL:
            begin
                poll_q = v;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic logic [LIMIT_W-1:0] pick_window();
        logic [LIMIT_W-1:0] w;
        // The bits above the register width are random and must be ignored.
        w = $urandom;
        case ($urandom_range(0, 9))
            0:       w[WIN_W-1:0] = WIN_W'($urandom_range(0, 1));
            1:       w[WIN_W-1:0] = WIN_W'(WINDOW_DEPTH);
            2:       w[WIN_W-1:0] = WIN_W'($urandom_range(WINDOW_DEPTH + 1, (1 << WIN_W) - 1));
            3:       w[WIN_W-1:0] = WIN_W'($urandom_range(9, WINDOW_DEPTH - 1));
            default: w[WIN_W-1:0] = WIN_W'($urandom_range(2, 8));
        endcase
        return w;
    endfunction

    task automatic send_tick(input logic [DATA_W-1:0] rss, input logic [DATA_W-1:0] cpu,
                             input bit known, input flags_t typed);
        flags_t f;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cpu, rss};
        do
            @(posedge clk);
        while (!s_axis_tready);
        f = predict_flags(rss, cpu);
        pending_flags.push_back(known ? typed : f);
        ticks_sent++;
    endtask

    task automatic release_sender();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        release_sender();
        while (pending_flags.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(idx, v);
        regs_written++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        flags_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            mem_flags_seen += m_axis_tdata[0];
            cpu_flags_seen += m_axis_tdata[1];
            if (pending_flags.size() == 0)
            begin
                errors++;
                $error("result word with no tick outstanding: tdata %h", m_axis_tdata);
            end
            else
            begin
                want = pending_flags.pop_front();
                if (m_axis_tdata[0] !== want.mem_over)
                begin
                    errors++;
                    $error("mem_over: expected %0b, actual %0b", want.mem_over, m_axis_tdata[0]);
                end
                if (m_axis_tdata[1] !== want.cpu_over)
                begin
                    errors++;
                    $error("cpu_over: expected %0b, actual %0b", want.cpu_over, m_axis_tdata[1]);
                end
                if (m_axis_tdata[7:2] !== 6'b0)
                begin
                    errors++;
                    $error("pad: expected 0, actual %h", m_axis_tdata[7:2]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no word moved for %0d cycles.", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : receiver
        int pattern;
        int span;
        int hold_at;
        hold_at = 200;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            // A long stall fills the block while the sender keeps offering words.
            if (results_seen >= hold_at)
            begin
                hold_at += 700;
                @(negedge clk);
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            pattern = $urandom_range(0, 3);
            span    = $urandom_range(20, 300);
            repeat (span)
            begin
                @(negedge clk);
                case (pattern)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 1) == 0);
                    2:       m_axis_tready <= ($urandom_range(0, 9) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int                 r;
        int                 k;
        int                 n;
        int                 pause_at;
        int                 burst_left;
        int                 rate_top;
        int                 random_sent;
        flags_t             typed;
        logic [LIMIT_W-1:0] v;
        logic [DATA_W-1:0]  rss;
        logic [DATA_W-1:0]  cpu_count;
        logic [63:0]        poll_eff;
        logic [63:0]        step;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        mem_limit_q   = '0;
        mem_win_q     = WIN_W'(2);
        cpu_limit_q   = '0;
        cpu_win_q     = WIN_W'(2);
        poll_q        = POLL_RESET;
        clear_ring(MEM_RING);
        clear_ring(CPU_RING);

        plan = '{
            '{ROW_TICK_KNOWN, REG_MEM_LIMIT, 32'h0, SAMPLE_MAX, SAMPLE_MAX, 1'b0, 1'b0},
            '{ROW_TICK_KNOWN, REG_MEM_LIMIT, 32'h0, 48'h0, 48'h0, 1'b0, 1'b0},
            '{ROW_CFG, REG_MEM_LIMIT, 32'h1, 48'h0, 48'h0, 1'b0, 1'b0},
            '{ROW_CFG, REG_MEM_WINDOW, 32'h0, 48'h0, 48'h0, 1'b0, 1'b0},
            '{ROW_CFG, REG_CPU_LIMIT, 32'd100, 48'h0, 48'h0, 1'b0, 1'b0},
            '{ROW_CFG, REG_CPU_WINDOW, 32'hFFFF_FF01, 48'h0, 48'h0, 1'b0, 1'b0},
            '{ROW_CFG, REG_POLL, 32'h0, 48'h0, 48'h0, 1'b0, 1'b0},
            '{ROW_TICK_KNOWN, REG_MEM_LIMIT, 32'h0, SAMPLE_MAX, 48'h0, 1'b0, 1'b0},
            '{ROW_TICK_KNOWN, REG_MEM_LIMIT, 32'h0, SAMPLE_MAX, SAMPLE_MAX, 1'b1, 1'b1},
            '{ROW_TICK, REG_MEM_LIMIT, 32'h0, 48'h0, 48'h0, 1'b0, 1'b0},
            '{ROW_TICK, REG_MEM_LIMIT, 32'h0, 48'h2, 48'd101, 1'b0, 1'b0},
            '{ROW_CFG, REG_POLL, 32'hFFFF_FFFF, 48'h0, 48'h0, 1'b0, 1'b0},
            '{ROW_CFG, REG_CPU_WINDOW, 32'h3, 48'h0, 48'h0, 1'b0, 1'b0},
            '{ROW_CFG, REG_MEM_LIMIT, 32'hFFFF_FFFF, 48'h0, 48'h0, 1'b0, 1'b0},
            '{ROW_CFG, REG_MEM_WINDOW, 32'h7F, 48'h0, 48'h0, 1'b0, 1'b0},
            '{ROW_TICK_KNOWN, REG_MEM_LIMIT, 32'h0, SAMPLE_MAX, 48'h0, 1'b0, 1'b0},
            '{ROW_TICK_KNOWN, REG_MEM_LIMIT, 32'h0, SAMPLE_MAX, 48'h0000_FFFF_FFFF, 1'b0, 1'b0},
            '{ROW_TICK, REG_MEM_LIMIT, 32'h0, SAMPLE_MAX, 48'h0096_0000_0000, 1'b0, 1'b0},
            '{ROW_CFG, REG_UNUSED_LO, 32'h0, 48'h0, 48'h0, 1'b0, 1'b0},
            '{ROW_CFG, REG_UNUSED_HI, 32'hFFFF_FFFF, 48'h0, 48'h0, 1'b0, 1'b0},
            '{ROW_TICK, REG_MEM_LIMIT, 32'h0, SAMPLE_MAX, 48'h012C_0000_0000, 1'b0, 1'b0},
            '{ROW_CFG, REG_CPU_LIMIT, 32'h0, 48'h0, 48'h0, 1'b0, 1'b0},
            '{ROW_TICK_KNOWN, REG_MEM_LIMIT, 32'h0, 48'h0, SAMPLE_MAX, 1'b0, 1'b0},
            '{ROW_CFG, REG_MEM_LIMIT, 32'h0, 48'h0, 48'h0, 1'b0, 1'b0},
            '{ROW_TICK_KNOWN, REG_MEM_LIMIT, 32'h0, SAMPLE_MAX, SAMPLE_MAX, 1'b0, 1'b0},
            '{ROW_CFG, REG_CPU_LIMIT, 32'hFFFF_FF7F, 48'h0, 48'h0, 1'b0, 1'b0},
            '{ROW_TICK, REG_MEM_LIMIT, 32'h0, 48'h5, 48'h0, 1'b0, 1'b0}
        };

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < NUM_ROWS; r++)
        begin
            if (plan[r].kind == ROW_CFG)
            begin
                wait_drained();
                write_reg(plan[r].index, plan[r].value);
            end
            else
            begin
                typed.mem_over = plan[r].mem_over;
                typed.cpu_over = plan[r].cpu_over;
                send_tick(plan[r].rss, plan[r].cpu, plan[r].kind == ROW_TICK_KNOWN, typed);
            end
        end

        random_sent = 0;
        cpu_count   = DATA_W'({$urandom, $urandom});
        burst_left  = $urandom_range(1, 30);
        while (random_sent < RANDOM_TICKS)
        begin
            wait_drained();
            if ($urandom_range(0, 2) == 0)
            begin
                case ($urandom_range(0, 5))
                    0:       v = '0;
                    1:       v = '1;
                    2:       v = $urandom;
                    default: v = $urandom_range(1, 1 << 20);
                endcase
                write_reg(REG_MEM_LIMIT, v);
            end
            if ($urandom_range(0, 3) == 0)
            begin
                write_reg(REG_MEM_WINDOW, pick_window());
            end
            if ($urandom_range(0, 2) == 0)
            begin
                v = $urandom;
                case ($urandom_range(0, 6))
                    0:       v[CPU_LIMIT_W-1:0] = '0;
                    1:       v[CPU_LIMIT_W-1:0] = CPU_LIMIT_W'(1);
                    2:       v[CPU_LIMIT_W-1:0] = CPU_LIMIT_W'(100);
                    3:       v[CPU_LIMIT_W-1:0] = '1;
                    default: v[CPU_LIMIT_W-1:0] = CPU_LIMIT_W'($urandom_range(1, 100));
                endcase
                write_reg(REG_CPU_LIMIT, v);
            end
            if ($urandom_range(0, 3) == 0)
            begin
                write_reg(REG_CPU_WINDOW, pick_window());
            end
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 6))
                    0:       v = '0;
                    1:       v = 32'd1;
                    2:       v = '1;
                    3:       v = $urandom;
                    4:       v = POLL_RESET;
                    default: v = $urandom_range(1, 1000);
                endcase
                write_reg(REG_POLL, v);
            end
            if ($urandom_range(0, 7) == 0)
            begin
                write_reg(CFG_IDX_W'($urandom_range(int'(REG_UNUSED_LO), int'(REG_UNUSED_HI))),
                          $urandom);
            end
            if ($urandom_range(0, 1) == 0)
            begin
                cpu_count = DATA_W'({$urandom, $urandom});
            end

            poll_eff = (poll_q == '0) ? 64'd1 : 64'(poll_q);
            rate_top = $urandom_range(0, 2 * int'(cpu_limit_q) + 3);
            n        = $urandom_range(10, 80);
            pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n - 1) : -1;
            for (k = 0; k < n; k++)
            begin
                if (k == pause_at)
                begin
                    wait_drained();
                end
                case ($urandom_range(0, 15))
                    0:       rss = DATA_W'({$urandom, $urandom});
                    1:       rss = '0;
                    2:       rss = '1;
                    default: rss = DATA_W'((64'(mem_limit_q) * $urandom_range(0, 200)) / 100
                                           + $urandom_range(0, 3));
                endcase
                if ($urandom_range(0, 19) == 0)
                begin
                    cpu_count = DATA_W'({$urandom, $urandom});
                end
                else
                begin
                    step = poll_eff * $urandom_range(0, rate_top)
                           + ({$urandom, $urandom} % poll_eff);
                    cpu_count = cpu_count + DATA_W'(step);
                end
                send_tick(rss, cpu_count, 1'b0, '0);
                random_sent++;
                burst_left--;
                if (burst_left == 0)
                begin
                    release_sender();
                    repeat ($urandom_range(0, 19)) @(negedge clk);
                    burst_left = $urandom_range(1, 30);
                end
            end
        end

        wait_drained();
        repeat (200) @(posedge clk);

        $display("Ran %0d poll ticks and %0d register writes, %0d result words checked.",
                 ticks_sent, regs_written, results_seen);
        $display("Memory flag raised %0d times, CPU flag raised %0d times.",
                 mem_flags_seen, cpu_flags_seen);
        if (errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- windowed_resource_limit_monitor.f -----
rtl/wrlm_pkg.sv
rtl/wrlm_ring.sv
rtl/wrlm_alu.sv
rtl/windowed_resource_limit_monitor.sv
verif/tb_top.sv
